[rtl/gamepad_report_formatter_core_assert.svh]
// Assertion helpers for the report formatter checker.
`ifndef GAMEPAD_REPORT_FORMATTER_CORE_ASSERT_SVH
`define GAMEPAD_REPORT_FORMATTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define GRF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("grf check failed");

// Next-cycle implication, disabled while in reset.
`define GRF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("grf check failed");

`endif

[rtl/grf_pkg.sv]
package grf_pkg;

    localparam int TICK_BITS = 32;

    localparam logic [15:0] LATCH_RESET = 16'd55;

    localparam int BIT_R_POS      = 14;
    localparam int BIT_ZR_POS     = 15;
    localparam int DPAD_DOWN_POS  = 24;
    localparam int DPAD_UP_POS    = 25;
    localparam int DPAD_RIGHT_POS = 26;
    localparam int DPAD_LEFT_POS  = 27;

    localparam int PACK_BITS = 19;

    localparam logic [4:0] PACK_SRC [PACK_BITS] = '{
        5'd11, 5'd10, 5'd9,  5'd8,
        5'd30, 5'd14, 5'd31, 5'd15,
        5'd16, 5'd17, 5'd19, 5'd18,
        5'd20, 5'd21, 5'd22, 5'd29,
        5'd28, 5'd13, 5'd12
    };

    // round(mag * 127 / 2047) = floor((254 * mag + 2047) / 4094)
    // floor(n / 4094) = (n * STICK_RECIP) >> STICK_SHIFT, exact for n < 2^19
    localparam logic [12:0] STICK_MID   = 13'd2047;
    localparam logic [19:0] STICK_RECIP = 20'd524545;
    localparam int          STICK_SHIFT = 31;

    // round(mag * 127 / 8192) = (254 * mag + 8192) >> 14
    localparam logic [16:0] RATE_FULL  = 17'd8192;
    localparam int          RATE_SHIFT = 14;

    localparam logic [7:0] AXIS_GAIN2 = 8'd254;

    typedef enum logic [3:0] {
        HAT_CENTER,
        HAT_UP,
        HAT_UP_RIGHT,
        HAT_RIGHT,
        HAT_DOWN_RIGHT,
        HAT_DOWN,
        HAT_DOWN_LEFT,
        HAT_LEFT,
        HAT_UP_LEFT
    } t_hat;

    typedef struct packed {
        logic left_valid;
        logic right_valid;
        logic pointer_mode;
        logic upd;
    } t_btn_ctl;

endpackage

[rtl/gamepad_report_formatter_core.sv]
// Pipeline: input register, then result register, which drives the output.
// Throughput: one report per cycle unless the output stalls; stretcher state (previous
// word, 32 hold deadlines) is read with each report and updated when a side is valid.
// Reset: synchronous, active low; clears both pipeline valids, the previous word,
// all hold deadlines, and loads latch_ticks with 55.
module gamepad_report_formatter_core #(
    parameter int TICK_BITS = grf_pkg::TICK_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata,

    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [31:0]        i_now_ticks,
    input  logic               i_left_valid,
    input  logic [31:0]        i_left_buttons,
    input  logic [11:0]        i_left_stick_x,
    input  logic [11:0]        i_left_stick_y,
    input  logic               i_right_valid,
    input  logic [31:0]        i_right_buttons,
    input  logic [11:0]        i_right_stick_x,
    input  logic [11:0]        i_right_stick_y,
    input  logic signed [15:0] i_rate_x_in,
    input  logic signed [15:0] i_rate_y_in,
    input  logic               i_pointer_mode,

    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [3:0]         o_hat,
    output logic [18:0]        o_pad_buttons,
    output logic signed [7:0]  o_stick_lx,
    output logic signed [7:0]  o_stick_ly,
    output logic signed [7:0]  o_stick_rx,
    output logic signed [7:0]  o_stick_ry,
    output logic signed [7:0]  o_pad_rate_x,
    output logic signed [7:0]  o_pad_rate_y
);

    logic [15:0]        r_latch;

    logic               r_s1_valid;
    logic [31:0]        r_now;
    logic               r_lv;
    logic [31:0]        r_lbtn;
    logic [11:0]        r_lx;
    logic [11:0]        r_ly;
    logic               r_rv;
    logic [31:0]        r_rbtn;
    logic [11:0]        r_rx;
    logic [11:0]        r_ry;
    logic signed [15:0] r_gx;
    logic signed [15:0] r_gy;
    logic               r_mouse;

    logic               r_out_valid;
    grf_pkg::t_hat      r_hat;
    logic [18:0]        r_pad;
    logic signed [7:0]  r_lx_o;
    logic signed [7:0]  r_ly_o;
    logic signed [7:0]  r_rx_o;
    logic signed [7:0]  r_ry_o;
    logic signed [7:0]  r_gx_o;
    logic signed [7:0]  r_gy_o;

    logic               s1_adv;
    logic               in_take;
    logic               any_valid;
    grf_pkg::t_btn_ctl  btn_ctl;
    grf_pkg::t_hat      hat;
    logic [18:0]        pad;
    grf_pkg::t_hat      n_hat;
    logic [18:0]        n_pad;
    logic signed [7:0]  n_lx;
    logic signed [7:0]  n_ly;
    logic signed [7:0]  n_rx;
    logic signed [7:0]  n_ry;
    logic signed [7:0]  n_gx;
    logic signed [7:0]  n_gy;

    assign s1_adv     = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_take    = i_in_valid && o_in_ready;
    assign any_valid  = r_lv || r_rv;

    assign btn_ctl.left_valid   = r_lv;
    assign btn_ctl.right_valid  = r_rv;
    assign btn_ctl.pointer_mode = r_mouse;
    assign btn_ctl.upd          = s1_adv && r_s1_valid && any_valid;

    grf_stretch #(
        .TICK_BITS (TICK_BITS)
    ) u_stretch (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (btn_ctl),
        .i_now_ticks     (r_now),
        .i_left_buttons  (r_lbtn),
        .i_right_buttons (r_rbtn),
        .i_latch_ticks   (r_latch),
        .o_hat           (hat),
        .o_pad_buttons   (pad)
    );

    grf_stick_scale u_lx (.i_valid(r_lv), .i_negate(1'b0), .i_raw(r_lx), .o_axis(n_lx));
    grf_stick_scale u_ly (.i_valid(r_lv), .i_negate(1'b1), .i_raw(r_ly), .o_axis(n_ly));
    grf_stick_scale u_rx (.i_valid(r_rv), .i_negate(1'b0), .i_raw(r_rx), .o_axis(n_rx));
    grf_stick_scale u_ry (.i_valid(r_rv), .i_negate(1'b1), .i_raw(r_ry), .o_axis(n_ry));

    // gyro axes swap: output X from input Y, output Y from negated input X
    grf_rate_scale u_gx (.i_valid(r_rv), .i_negate(1'b0), .i_raw(r_gy), .o_axis(n_gx));
    grf_rate_scale u_gy (.i_valid(r_rv), .i_negate(1'b1), .i_raw(r_gx), .o_axis(n_gy));

    assign n_hat = any_valid ? hat : grf_pkg::HAT_CENTER;
    assign n_pad = any_valid ? pad : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch     <= grf_pkg::LATCH_RESET;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_latch <= i_cfg_wdata;
            end
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_now   <= i_now_ticks;
            r_lv    <= i_left_valid;
            r_lbtn  <= i_left_buttons;
            r_lx    <= i_left_stick_x;
            r_ly    <= i_left_stick_y;
            r_rv    <= i_right_valid;
            r_rbtn  <= i_right_buttons;
            r_rx    <= i_right_stick_x;
            r_ry    <= i_right_stick_y;
            r_gx    <= i_rate_x_in;
            r_gy    <= i_rate_y_in;
            r_mouse <= i_pointer_mode;
        end
        if (s1_adv && r_s1_valid) begin
            r_hat  <= n_hat;
            r_pad  <= n_pad;
            r_lx_o <= n_lx;
            r_ly_o <= n_ly;
            r_rx_o <= n_rx;
            r_ry_o <= n_ry;
            r_gx_o <= n_gx;
            r_gy_o <= n_gy;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hat         = r_hat;
    assign o_pad_buttons = r_pad;
    assign o_stick_lx    = r_lx_o;
    assign o_stick_ly    = r_ly_o;
    assign o_stick_rx    = r_rx_o;
    assign o_stick_ry    = r_ry_o;
    assign o_pad_rate_x  = r_gx_o;
    assign o_pad_rate_y  = r_gy_o;

endmodule

[rtl/grf_stretch.sv]
module grf_stretch #(
    parameter int TICK_BITS = grf_pkg::TICK_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  grf_pkg::t_btn_ctl       i_ctl,
    input  logic [31:0]             i_now_ticks,
    input  logic [31:0]             i_left_buttons,
    input  logic [31:0]             i_right_buttons,
    input  logic [15:0]             i_latch_ticks,
    output grf_pkg::t_hat           o_hat,
    output logic [grf_pkg::PACK_BITS-1:0] o_pad_buttons
);

    logic [31:0]          raw;
    logic [31:0]          pressed;
    logic [31:0]          hold;
    logic [31:0]          word;
    logic [TICK_BITS-1:0] now_t;
    logic [TICK_BITS-1:0] dl_new;
    logic [TICK_BITS-1:0] diff [32];

    logic [31:0]          r_prev;
    logic [31:0]          n_prev;
    logic [TICK_BITS-1:0] r_dl [32];
    logic [TICK_BITS-1:0] n_dl [32];

    always_comb begin
        raw = ({32{i_ctl.left_valid}} & i_left_buttons)
            | ({32{i_ctl.right_valid}} & i_right_buttons);
        if (i_ctl.pointer_mode) begin
            raw[grf_pkg::BIT_R_POS]  = 1'b0;
            raw[grf_pkg::BIT_ZR_POS] = 1'b0;
        end
    end

    assign pressed = raw & ~r_prev;
    assign n_prev  = raw;
    assign now_t   = TICK_BITS'(i_now_ticks);
    assign dl_new  = now_t + TICK_BITS'(i_latch_ticks);

    // hold while deadline set and (deadline - now) is positive as a signed value
    always_comb begin
        for (int i = 0; i < 32; i++) begin
            diff[i] = r_dl[i] - now_t;
            hold[i] = (|r_dl[i]) && (|diff[i]) && !diff[i][TICK_BITS-1];
            n_dl[i] = pressed[i] ? dl_new : r_dl[i];
        end
    end

    assign word = raw | hold;

    always_comb begin
        for (int i = 0; i < grf_pkg::PACK_BITS; i++) begin
            o_pad_buttons[i] = word[grf_pkg::PACK_SRC[i]];
        end
    end

    always_comb begin
        logic up, dn, lf, rt;
        up = word[grf_pkg::DPAD_UP_POS];
        dn = word[grf_pkg::DPAD_DOWN_POS];
        lf = word[grf_pkg::DPAD_LEFT_POS];
        rt = word[grf_pkg::DPAD_RIGHT_POS];
        if (up && rt) begin
            o_hat = grf_pkg::HAT_UP_RIGHT;
        end else if (rt && dn) begin
            o_hat = grf_pkg::HAT_DOWN_RIGHT;
        end else if (dn && lf) begin
            o_hat = grf_pkg::HAT_DOWN_LEFT;
        end else if (lf && up) begin
            o_hat = grf_pkg::HAT_UP_LEFT;
        end else if (up) begin
            o_hat = grf_pkg::HAT_UP;
        end else if (rt) begin
            o_hat = grf_pkg::HAT_RIGHT;
        end else if (dn) begin
            o_hat = grf_pkg::HAT_DOWN;
        end else if (lf) begin
            o_hat = grf_pkg::HAT_LEFT;
        end else begin
            o_hat = grf_pkg::HAT_CENTER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            for (int i = 0; i < 32; i++) begin
                r_dl[i] <= '0;
            end
        end else if (i_ctl.upd) begin
            r_prev <= n_prev;
            for (int i = 0; i < 32; i++) begin
                r_dl[i] <= n_dl[i];
            end
        end
    end

endmodule

[rtl/grf_stick_scale.sv]
module grf_stick_scale (
    input  logic              i_valid,
    input  logic              i_negate,
    input  logic [11:0]       i_raw,
    output logic signed [7:0] o_axis
);

    logic signed [12:0] d;
    logic [12:0]        abs_d;
    logic [10:0]        mag;
    logic [18:0]        num;
    logic [38:0]        prod;
    logic [6:0]         q;
    logic               neg;

    assign d     = $signed({1'b0, i_raw}) - $signed(grf_pkg::STICK_MID);
    assign abs_d = d[12] ? 13'(-d) : 13'(d);
    assign mag   = (abs_d > grf_pkg::STICK_MID) ? 11'(grf_pkg::STICK_MID) : abs_d[10:0];
    assign num   = 19'(mag) * 19'(grf_pkg::AXIS_GAIN2) + 19'(grf_pkg::STICK_MID);
    assign prod  = 39'(num) * 39'(grf_pkg::STICK_RECIP);
    assign q     = prod[grf_pkg::STICK_SHIFT +: 7];
    assign neg   = d[12] ^ i_negate;

    always_comb begin
        if (!i_valid) begin
            o_axis = '0;
        end else if (neg) begin
            o_axis = -$signed({1'b0, q});
        end else begin
            o_axis = $signed({1'b0, q});
        end
    end

endmodule

[rtl/grf_rate_scale.sv]
module grf_rate_scale (
    input  logic               i_valid,
    input  logic               i_negate,
    input  logic signed [15:0] i_raw,
    output logic signed [7:0]  o_axis
);

    logic [16:0] abs_r;
    logic [13:0] mag;
    logic [21:0] num;
    logic [6:0]  q;
    logic        neg;

    assign abs_r = i_raw[15] ? 17'(-{i_raw[15], i_raw}) : 17'({i_raw[15], i_raw});
    assign mag   = (abs_r > grf_pkg::RATE_FULL) ? 14'(grf_pkg::RATE_FULL) : abs_r[13:0];
    assign num   = 22'(mag) * 22'(grf_pkg::AXIS_GAIN2) + 22'(grf_pkg::RATE_FULL);
    assign q     = num[grf_pkg::RATE_SHIFT +: 7];
    assign neg   = i_raw[15] ^ i_negate;

    always_comb begin
        if (!i_valid) begin
            o_axis = '0;
        end else if (neg) begin
            o_axis = -$signed({1'b0, q});
        end else begin
            o_axis = $signed({1'b0, q});
        end
    end

endmodule

[rtl/grf_checker.sv]
`include "gamepad_report_formatter_core_assert.svh"

module grf_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [3:0]        o_hat,
    input logic [18:0]       o_pad_buttons,
    input logic signed [7:0] o_stick_lx,
    input logic signed [7:0] o_stick_ly,
    input logic signed [7:0] o_stick_rx,
    input logic signed [7:0] o_stick_ry,
    input logic signed [7:0] o_pad_rate_x,
    input logic signed [7:0] o_pad_rate_y
);

    logic stall;
    logic no_min;

    assign stall  = o_out_valid && !i_out_ready;
    assign no_min = (o_stick_lx != 8'sh80) && (o_stick_ly != 8'sh80)
                 && (o_stick_rx != 8'sh80) && (o_stick_ry != 8'sh80)
                 && (o_pad_rate_x != 8'sh80) && (o_pad_rate_y != 8'sh80);

    `GRF_ASSERT_NXT(a_out_hold, stall, o_out_valid && $stable(o_pad_buttons) && $stable(o_hat))
    `GRF_ASSERT_IMP(a_hat_range, o_out_valid, o_hat <= grf_pkg::HAT_UP_LEFT)
    `GRF_ASSERT_IMP(a_axis_sym, o_out_valid, no_min)
    `GRF_ASSERT_IMP(a_ready_when_empty, !o_out_valid, o_in_ready)
    `GRF_ASSERT_IMP(a_reset_empty, $past(!i_rst_n), !o_out_valid)

endmodule

bind gamepad_report_formatter_core grf_checker u_grf_checker (.*);
